@@ design/tsil_pkg.sv @@
// Shared constants and types for the totient sieve with inverse lookup.
// No dependencies; imported by tsil_scan, totient_sieve_inverse_lookup and tb_top.
`timescale 1ns / 1ps

package tsil_pkg;

    localparam int unsigned DEFAULT_TABLE_SIZE = 65536;
    localparam int unsigned TARGET_W           = 16;
    localparam int unsigned INDEX_OUT_W        = 17;

    // Status of the query scan engine as seen by the table controller
    typedef struct packed {
        logic active;   // a query is in progress
        logic issue;    // a table read is issued this cycle
    } scan_stat_t;

endpackage

@@ design/tsil_scan.sv @@
// Query scan engine: walks the totient table upward from index 1, one read per cycle,
// and reports the first index whose totient matches the target. Depends on tsil_pkg.
`timescale 1ns / 1ps

module tsil_scan
    import tsil_pkg::*;
#(
    parameter int unsigned TABLE_SIZE = DEFAULT_TABLE_SIZE,
    parameter int unsigned IW         = 17,
    parameter int unsigned TW         = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   go,
    input  logic [TARGET_W-1:0]    target,
    input  logic [TW-1:0]          rd_phi,
    output logic [IW-1:0]          rd_addr,
    output scan_stat_t             stat,
    output logic                   done,
    output logic                   found,
    output logic [INDEX_OUT_W-1:0] first_index
);

    localparam int unsigned CW = (TW > TARGET_W) ? TW : TARGET_W;

    logic                   active_reg, active_next;
    logic                   last_reg, last_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]          addr_reg, addr_next;
    logic [IW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [TARGET_W-1:0]    target_reg, target_next;
    logic                   done_reg, done_next;
    logic                   found_reg, found_next;
    logic [INDEX_OUT_W-1:0] first_index_reg, first_index_next;

    logic hit;
    logic miss_end;
    logic issue;

    assign hit      = active_reg && cmp_vld_reg && (CW'(rd_phi) == CW'(target_reg));
    assign miss_end = active_reg && last_reg && !hit;
    assign issue    = active_reg && !last_reg && !hit;

    always_comb
    begin
        active_next      = active_reg;
        last_next        = last_reg;
        cmp_vld_next     = issue;
        addr_next        = addr_reg;
        cmp_idx_next     = cmp_idx_reg;
        target_next      = target_reg;
        done_next        = 1'b0;
        found_next       = found_reg;
        first_index_next = first_index_reg;

        if (go)
        begin
            active_next  = 1'b1;
            last_next    = 1'b0;
            cmp_vld_next = 1'b0;
            addr_next    = IW'(1);
            target_next  = target;
        end
        else if (hit)
        begin
            active_next      = 1'b0;
            done_next        = 1'b1;
            found_next       = 1'b1;
            first_index_next = INDEX_OUT_W'(cmp_idx_reg);
        end
        else if (miss_end)
        begin
            active_next      = 1'b0;
            done_next        = 1'b1;
            found_next       = 1'b0;
            first_index_next = '0;
        end
        else if (issue)
        begin
            // advance; flag the final table index
            cmp_idx_next = addr_reg;
            addr_next    = addr_reg + 1'b1;
            last_next    = (addr_reg == IW'(TABLE_SIZE));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            last_reg    <= 1'b0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            last_reg    <= last_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg        <= addr_next;
        cmp_idx_reg     <= cmp_idx_next;
        target_reg      <= target_next;
        found_reg       <= found_next;
        first_index_reg <= first_index_next;
    end

    assign rd_addr     = addr_reg;
    assign stat.active = active_reg;
    assign stat.issue  = issue;
    assign done        = done_reg;
    assign found       = found_reg;
    assign first_index = first_index_reg;

`ifndef SYNTHESIS
    // a compare only follows a read issued in the cycle before
    a_cmp_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> $past(issue))
        else $error("scan compare without a preceding table read");

    // the engine never reads past the end of the table
    a_no_read_past_end: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (addr_reg <= IW'(TABLE_SIZE)) && (addr_reg != '0))
        else $error("scan read address outside 1..TABLE_SIZE");

    // a result beat closes the query in the same cycle
    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !active_reg && $past(active_reg))
        else $error("result beat without an open query");
`endif

endmodule

@@ design/totient_sieve_inverse_lookup.sv @@
// Top level: totient table built by a linear sieve, then smallest-preimage queries.
// Holds the totient/factor table and prime list memories; depends on tsil_pkg, tsil_scan.
`timescale 1ns / 1ps

// After reset the block is busy while it builds its table. It first clears the table
// memory, one entry a cycle over indices 0..TABLE_SIZE, then runs a linear sieve over
// 2..TABLE_SIZE: for each index it reads and checks the entry, then for each prime it
// reads the prime, forms the product, works out its totient and writes it into the
// table, stopping at the index's least prime factor, at the prime whose product runs
// past the end, or when the primes run out. Once busy falls, a query beat is taken at
// a clock edge with start high and busy low. The scan then reads one table entry per
// cycle from index 1 upward, and the result beat follows the compare of the first
// matching index, or of index TABLE_SIZE when nothing matches. done marks the result
// and is high for exactly one cycle; found and first_index hold it until the next
// result beat; sample it then. busy falls in the same cycle as done, and the next start
// may follow at once. A target of zero, or one no index maps to, gives found low and
// index zero.

module totient_sieve_inverse_lookup
    import tsil_pkg::*;
#(
    parameter int unsigned TABLE_SIZE = DEFAULT_TABLE_SIZE
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [TARGET_W-1:0]    target_value,
    output logic                   done,
    output logic                   found,
    output logic [INDEX_OUT_W-1:0] first_index
);

    // Index, totient and prime-list geometry
    localparam int unsigned IW    = $clog2(TABLE_SIZE + 1);
    localparam int unsigned TW    = $clog2(TABLE_SIZE);
    localparam int unsigned WW    = IW + TW;
    localparam int unsigned DEPTH = TABLE_SIZE + 1;
    localparam int unsigned PD    = TABLE_SIZE / 2 + 2;
    localparam int unsigned PW    = $clog2(PD);
    localparam int unsigned MW    = 2 * IW;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_SEED,
        S_RD_I,
        S_CHK_I,
        S_K_RD,
        S_K_MUL,
        S_K_PHI,
        S_K_WR,
        S_READY
    } state_t;

    // Table word: {least prime factor, totient}. A zero factor field means the index
    // has not been marked composite yet, which stands in for the composite flag.
    logic [WW-1:0] tbl_mem [DEPTH];
    logic [IW-1:0] prm_mem [PD];

    logic          tbl_we;
    logic [IW-1:0] tbl_waddr;
    logic [WW-1:0] tbl_wdata;
    logic          tbl_re;
    logic [IW-1:0] tbl_raddr;
    logic [WW-1:0] tbl_rdata_reg;

    logic          prm_we;
    logic [PW-1:0] prm_waddr;
    logic [IW-1:0] prm_wdata;
    logic [PW-1:0] prm_raddr;
    logic [IW-1:0] prm_rdata_reg;

    state_t        state_reg, state_next;
    logic [IW-1:0] clr_addr_reg, clr_addr_next;
    logic [IW-1:0] i_reg, i_next;
    logic [PW-1:0] pcount_reg, pcount_next;
    logic [PW-1:0] k_reg, k_next;

    logic [IW-1:0] lpf_i_reg, lpf_i_next;
    logic [TW-1:0] phi_i_reg, phi_i_next;
    logic [IW-1:0] p_reg, p_next;
    logic [MW-1:0] m_reg, m_next;
    logic [TW-1:0] phi_m_reg, phi_m_next;

    logic [IW-1:0] rd_lpf;
    logic [TW-1:0] rd_phi;
    logic [IW-1:0] factor;
    logic          last_i;
    logic          ready;

    logic          scan_go;
    logic [IW-1:0] scan_addr;
    scan_stat_t    scan_stat;

    assign rd_lpf = tbl_rdata_reg[WW-1:TW];
    assign rd_phi = tbl_rdata_reg[TW-1:0];
    // p divides i exactly when p is i's least prime factor, as primes go in order
    assign factor = (p_reg == lpf_i_reg) ? p_reg : (p_reg - 1'b1);
    assign last_i = (i_reg == IW'(TABLE_SIZE));
    assign ready  = (state_reg == S_READY);

    assign busy    = !ready || scan_stat.active;
    assign scan_go = start && !busy;

    // ------------------------------------------------------------------
    // Sieve sequencer and table port control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        i_next        = i_reg;
        pcount_next   = pcount_reg;
        k_next        = k_reg;
        lpf_i_next    = lpf_i_reg;
        phi_i_next    = phi_i_reg;
        p_next        = p_reg;
        m_next        = m_reg;
        phi_m_next    = phi_m_reg;

        tbl_we    = 1'b0;
        tbl_waddr = clr_addr_reg;
        tbl_wdata = '0;
        tbl_re    = 1'b0;
        tbl_raddr = scan_addr;
        prm_we    = 1'b0;
        prm_waddr = pcount_reg;
        prm_wdata = i_reg;
        prm_raddr = k_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                // sweep the table to zero, one entry a cycle
                tbl_we        = 1'b1;
                tbl_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == IW'(TABLE_SIZE))
                begin
                    state_next = S_SEED;
                end
            end
            S_SEED:
            begin
                // index one: totient one, marked non-prime
                tbl_we     = 1'b1;
                tbl_waddr  = IW'(1);
                tbl_wdata  = {IW'(1), TW'(1)};
                i_next     = IW'(2);
                state_next = S_RD_I;
            end
            S_RD_I:
            begin
                tbl_re     = 1'b1;
                tbl_raddr  = i_reg;
                state_next = S_CHK_I;
            end
            S_CHK_I:
            begin
                k_next     = '0;
                state_next = S_K_RD;
                if (rd_lpf == '0)
                begin
                    // unmarked: a new prime, append it and store its totient
                    lpf_i_next  = i_reg;
                    phi_i_next  = TW'(i_reg - 1'b1);
                    tbl_we      = 1'b1;
                    tbl_waddr   = i_reg;
                    tbl_wdata   = {i_reg, TW'(i_reg - 1'b1)};
                    prm_we      = 1'b1;
                    pcount_next = pcount_reg + 1'b1;
                end
                else
                begin
                    lpf_i_next = rd_lpf;
                    phi_i_next = rd_phi;
                end
            end
            S_K_RD:
            begin
                if (k_reg < pcount_reg)
                begin
                    state_next = S_K_MUL;
                end
                else if (last_i)
                begin
                    state_next = S_READY;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RD_I;
                end
            end
            S_K_MUL:
            begin
                p_next     = prm_rdata_reg;
                m_next     = {{IW{1'b0}}, prm_rdata_reg} * {{IW{1'b0}}, i_reg};
                state_next = S_K_PHI;
            end
            S_K_PHI:
            begin
                if (m_reg > MW'(TABLE_SIZE))
                begin
                    // product beyond the table: drop the rest of the primes
                    if (last_i)
                    begin
                        state_next = S_READY;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_RD_I;
                    end
                end
                else
                begin
                    phi_m_next = TW'({{TW{1'b0}}, factor} * {{IW{1'b0}}, phi_i_reg});
                    state_next = S_K_WR;
                end
            end
            S_K_WR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = m_reg[IW-1:0];
                tbl_wdata = {p_reg, phi_m_reg};
                if (p_reg == lpf_i_reg)
                begin
                    if (last_i)
                    begin
                        state_next = S_READY;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_RD_I;
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_K_RD;
                end
            end
            S_READY:
            begin
                // table is read only by the query scan from here on
                tbl_re    = scan_stat.issue;
                tbl_raddr = scan_addr;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            i_reg        <= '0;
            pcount_reg   <= '0;
            k_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            i_reg        <= i_next;
            pcount_reg   <= pcount_next;
            k_reg        <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lpf_i_reg <= lpf_i_next;
        phi_i_reg <= phi_i_next;
        p_reg     <= p_next;
        m_reg     <= m_next;
        phi_m_reg <= phi_m_next;
    end

    // ------------------------------------------------------------------
    // Memories: one write and one registered read per cycle each. The sequencer
    // never has a write and a read of the same entry in flight together.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re)
        begin
            tbl_rdata_reg <= tbl_mem[tbl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prm_we)
        begin
            prm_mem[prm_waddr] <= prm_wdata;
        end
        prm_rdata_reg <= prm_mem[prm_raddr];
    end

    // ------------------------------------------------------------------
    // Query scan
    // ------------------------------------------------------------------
    tsil_scan #(
        .TABLE_SIZE (TABLE_SIZE),
        .IW         (IW),
        .TW         (TW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (scan_go),
        .target      (target_value),
        .rd_phi      (rd_phi),
        .rd_addr     (scan_addr),
        .stat        (scan_stat),
        .done        (done),
        .found       (found),
        .first_index (first_index)
    );

`ifndef SYNTHESIS
    // no query runs until the sieve has finished
    a_scan_after_sieve: assert property (@(posedge clk) disable iff (!rst_n)
        scan_stat.active |-> ready)
        else $error("query scan active before the sieve finished");

    // the prime list is frozen once the table is built
    a_primes_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        ready |=> $stable(pcount_reg) && ready)
        else $error("prime count moved after the sieve finished");

    // outside the clearing pass, writes come only from the sieve and stay in the table
    a_write_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (tbl_we && state_reg != S_CLEAR) |-> (tbl_waddr <= IW'(TABLE_SIZE)) && !ready)
        else $error("table written outside the sieve or beyond its end");

    // a not-found beat carries index zero
    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (first_index == '0))
        else $error("not-found result with a non-zero index");
`endif

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for totient_sieve_inverse_lookup: query beats in, answer beats checked.
// Depends on tsil_pkg and the design top; the expected answers come from its own sieve.
`timescale 1ns / 1ps

module tb_top;
    import tsil_pkg::*;

    localparam int unsigned TABLE_SIZE  = DEFAULT_TABLE_SIZE;
    // The longest quiet stretch in a correct run is the clearing pass plus the sieve;
    // QUIET_LIMIT allows several times that.
    localparam int unsigned QUIET_LIMIT = 40 * TABLE_SIZE;
    localparam int unsigned RANDOM_QUERIES = 100;

    // Directed targets, in order:
    //   one       - answered by index 1, sent while the sieve is still running
    //   zero      - no index has a totient of zero
    //   two       - smallest preimage is 3, not 4 or 6
    //   all ones  - odd, so no index maps to it
    //   a few small even totients, then the top bit alone (preimage near the end of
    //   the table), the totient of the largest prime in the table, and sixteen
    localparam logic [TARGET_W-1:0] DIRECTED [10] = '{
        16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd4, 16'd6, 16'd12, 16'h8000, 16'd65520, 16'd16
    };

    // One expected answer beat
    typedef struct packed {
        logic                   hit;
        logic [INDEX_OUT_W-1:0] idx;
    } preimage_t;

    // Scoreboard: holds a private totient table and the smallest preimage of every
    // 16-bit value, and queues the answer owed for each query beat taken.
    class preimage_board;
        int unsigned phi_tab[];
        int unsigned least_idx[];
        preimage_t   owed[$];
        int          faults;

        function new(int unsigned size);
            int unsigned     primes[$];
            bit              marked[];
            int unsigned     p;
            longint unsigned m;
            phi_tab   = new[size + 1];
            marked    = new[size + 1];
            least_idx = new[1 << TARGET_W];
            faults    = 0;
            phi_tab[0] = 0;
            phi_tab[1] = 1;
            marked[1]  = 1'b1;
            // Linear sieve: every composite is struck once, by its smallest prime factor
            for (int unsigned i = 2; i <= size; i++)
            begin
                if (!marked[i])
                begin
                    phi_tab[i] = i - 1;
                    primes.push_back(i);
                end
                for (int k = 0; k < primes.size(); k++)
                begin
                    p = primes[k];
                    m = longint'(p) * i;
                    if (m > size)
                        break;
                    marked[m] = 1'b1;
                    if (i % p == 0)
                    begin
                        phi_tab[m] = p * phi_tab[i];
                        break;
                    end
                    phi_tab[m] = (p - 1) * phi_tab[i];
                end
            end
            // Keep the first index seen for each totient; zero means none
            for (int unsigned n = 1; n <= size; n++)
                if (phi_tab[n] < (1 << TARGET_W) && least_idx[phi_tab[n]] == 0)
                    least_idx[phi_tab[n]] = n;
        endfunction

        function void note_query(logic [TARGET_W-1:0] target);
            preimage_t e;
            e.idx = INDEX_OUT_W'(least_idx[target]);
            e.hit = (e.idx != 0);
            owed.push_back(e);
        endfunction

        function void check_answer(logic hit, logic [INDEX_OUT_W-1:0] idx);
            preimage_t e;
            if (owed.size() == 0)
            begin
                $error("answer beat with no query outstanding: found=%0d first_index=%0d",
                       hit, idx);
                faults++;
                return;
            end
            e = owed.pop_front();
            if (hit !== e.hit)
            begin
                $error("found: expected %0d, actual %0d", e.hit, hit);
                faults++;
            end
            if (idx !== e.idx)
            begin
                $error("first_index: expected %0d, actual %0d", e.idx, idx);
                faults++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [TARGET_W-1:0]    target_value = '0;
    logic                   busy;
    logic                   done;
    logic                   found;
    logic [INDEX_OUT_W-1:0] first_index;

    int unsigned   quiet_cycles = 0;
    preimage_board board;

    totient_sieve_inverse_lookup #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .target_value (target_value),
        .done         (done),
        .found        (found),
        .first_index  (first_index)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Check every answer beat at the edge that ends its single cycle
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            board.check_answer(found, first_index);
    end

    // Watchdog: count edges at which no beat moves either way
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one query beat and hold it until the block takes it. Drive on the falling
    // edge; a taken beat is seen at the rising edge with start high and busy low.
    task automatic send_query(input logic [TARGET_W-1:0] target, input bit steady);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 36)
            gap = $urandom_range(1, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            // Drop start for a random gap and scribble on the target meanwhile
            start        <= 1'b0;
            target_value <= TARGET_W'($urandom_range(0, (1 << TARGET_W) - 1));
            repeat (gap) @(negedge clk);
        end
        start        <= 1'b1;
        target_value <= target;
        do
            @(posedge clk);
        while (busy);
        board.note_query(target);
    endtask

    initial
    begin
        int unsigned         pick;
        int unsigned         n;
        logic [TARGET_W-1:0] t;

        board = new(TABLE_SIZE);

        // Hold reset, then release it on a falling edge
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // The first beat waits out the clearing pass and the sieve while busy is high
        foreach (DIRECTED[d])
            send_query(DIRECTED[d], 1'b0);

        // Mostly totients of small indices so each scan ends early; a few from anywhere
        // in the table, and a few raw values that usually match nothing. Keep a middle
        // stretch free of gaps so beats follow done back to back.
        for (int r = 0; r < RANDOM_QUERIES; r++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 93)
                n = $urandom_range(1, 2048);
            else
                n = $urandom_range(1, TABLE_SIZE);
            if (pick < 97)
                t = TARGET_W'(board.phi_tab[n]);
            else
                t = TARGET_W'($urandom_range(0, (1 << TARGET_W) - 1));
            send_query(t, r >= 40 && r < 70);
        end

        @(negedge clk);
        start <= 1'b0;

        // Drain outstanding answers, then watch a little longer for stray beats
        while (board.pending() > 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (board.faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
